### hdl/error_diffusion_dither_16_level_core_macros.svh
// ----------------------------------------------------------------------------
// error diffusion dither core: assertion macros
// concurrent check wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_DITHER_16_LEVEL_CORE_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_16_LEVEL_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define EDD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("edd16 same-cycle check failed");
// next-cycle implication
`define EDD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("edd16 next-cycle check failed");
`else
`define EDD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define EDD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### hdl/edd16_pkg.sv
// ----------------------------------------------------------------------------
// edd16_pkg
// types, diffusion weights and helpers of the 16-level dither core
// ----------------------------------------------------------------------------
`default_nettype none

package edd16_pkg;

    localparam int PIX_W  = 8;
    localparam int ERR_W  = 5;
    localparam int CFG_W  = 13;
    localparam int ROW_W  = 13;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // diffusion weights in sixteenths: right, bottom-left, bottom, bottom-right
    localparam logic [3:0] K_MID_R   = 4'd7;
    localparam logic [3:0] K_MID_BL  = 4'd3;
    localparam logic [3:0] K_MID_B   = 4'd5;
    localparam logic [3:0] K_MID_BR  = 4'd1;
    localparam logic [3:0] K_LEFT_R  = 4'd8;
    localparam logic [3:0] K_LEFT_B  = 4'd6;
    localparam logic [3:0] K_LEFT_BR = 4'd2;
    localparam logic [3:0] K_LAST_BL = 4'd7;
    localparam logic [3:0] K_LAST_B  = 4'd9;
    localparam logic [3:0] K_NONE    = 4'd0;

    // position flags of a pixel in the frame
    typedef struct packed {
        logic last_col;
        logic last_row;
        logic first_col;
        logic frame_end;
    } pos_t;

    // floor(e * k / 16)
    function automatic logic [ERR_W-1:0] share(input logic [3:0] e, input logic [3:0] k);
        logic [7:0] p;
        p = {4'b0000, e} * {4'b0000, k};
        return {1'b0, p[7:4]};
    endfunction

    function automatic logic [ERR_W-1:0] sat31(input logic [ERR_W:0] v);
        return v[ERR_W] ? {ERR_W{1'b1}} : v[ERR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/error_diffusion_dither_16_level_core.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither_16_level_core
// raster-order error-diffusion dither of 8-bit gray pixels to 16 levels
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  ------------------------------------
//  s_        in   s_tvalid / s_tready       s_tdata[7:0] pixel_in
//  m_        out  m_tvalid / m_tready       m_tdata[7:0] pixel_out, m_tlast frame_end
//  cfg_      in   cfg_valid / cfg_ready     cfg_index, cfg_data[12:0]
//
//  one pixel per cycle sustained while m_ does not stall; the row error
//  memory is read once and written once per pixel, so its single write
//  port sets the rate
//  a result passes the compute stage register, then the output register, to m_
//  after reset the row memory is swept to zero; s_tready stays low during
//  that sweep (configuration still taken)
//  a stall on m_ holds the pixel in the compute stage and keeps s_tready low
//
`default_nettype none
`include "error_diffusion_dither_16_level_core_macros.svh"

module error_diffusion_dither_16_level_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input pixel stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] pixel_in
    // dithered pixel stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] pixel_out
    output logic                              m_tlast,   // frame_end
    // configuration writes
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire edd16_pkg::cfg_reg_t          cfg_index,
    input  wire logic [edd16_pkg::CFG_W-1:0]  cfg_data
);
    import edd16_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = COL_W + 1;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(512);
            height_reg <= CFG_W'(512);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size: width clamped to 2..MAX_WIDTH, height to at least 2
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else if (width_reg < CFG_W'(2)) begin
            w_eff = WW'(2);
        end else begin
            w_eff = WW'(width_reg);
        end
        h_eff = (height_reg < CFG_W'(2)) ? ROW_W'(2) : ROW_W'(height_reg);
    end

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    logic             clr_active_reg;
    logic [COL_W-1:0] clr_addr_reg;
    logic             s1_valid_reg;
    logic             m_valid_reg;
    logic             s1_fire;
    logic             accept;

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr_active_reg && (!s1_valid_reg || s1_fire);
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // position counters, advanced per accepted request
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    pos_t             pos_now;

    always_comb begin
        pos_now.last_col  = (({1'b0, col_reg} + WW'(1)) >= w_eff);
        pos_now.last_row  = ((row_reg + ROW_W'(1)) >= h_eff);
        pos_now.first_col = (col_reg == '0);
        pos_now.frame_end = pos_now.last_col && pos_now.last_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (pos_now.last_col) begin
                col_reg <= '0;
                row_reg <= pos_now.last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // row error memory: one read on accept, one write on compute or sweep
    // ------------------------------------------------------------------
    logic [ERR_W-1:0] err_mem [MAX_WIDTH];
    logic [ERR_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [COL_W-1:0] mem_waddr;
    logic [ERR_W-1:0] mem_wdata;
    logic [ERR_W-1:0] wb_data;
    logic [COL_W-1:0] prev_col_reg;

    assign mem_we    = clr_active_reg || s1_fire;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : prev_col_reg;
    assign mem_wdata = clr_active_reg ? '0 : wb_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            err_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rd_data_reg <= err_mem[col_reg];
        end
    end

    // zeroing sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                clr_active_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // compute stage
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    pos_t             s1_pos_reg;
    logic             s1_fwd_reg;
    logic [ERR_W-1:0] s1_fwd_data_reg;

    // error carried along the row and the delayed write of the column to the left
    logic [ERR_W-1:0] right_carry_reg, right_carry_next;
    logic [ERR_W-1:0] pend_reg, pend_next;
    logic [ERR_W-1:0] left_reg, left_next;

    logic [ERR_W-1:0] buf_val;
    logic [9:0]       sum;
    logic [PIX_W-1:0] sat_val;
    logic [3:0]       err;
    logic [3:0]       k_r, k_bl, k_b, k_br;
    logic             fwd_hit;

    always_comb begin
        // the pixel ahead may read the entry written right now
        buf_val = s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg;
        sum     = 10'(s1_pix_reg) + 10'(right_carry_reg) + 10'(buf_val);
        sat_val = (sum > 10'd255) ? 8'hFF : sum[7:0];
        err     = sat_val[3:0];

        // weight selection by position
        if (s1_pos_reg.last_row) begin
            k_r  = K_NONE;
            k_bl = K_NONE;
            k_b  = K_NONE;
            k_br = K_NONE;
        end else if (s1_pos_reg.last_col) begin
            k_r  = K_NONE;
            k_bl = K_LAST_BL;
            k_b  = K_LAST_B;
            k_br = K_NONE;
        end else if (s1_pos_reg.first_col) begin
            k_r  = K_LEFT_R;
            k_bl = K_NONE;
            k_b  = K_LEFT_B;
            k_br = K_LEFT_BR;
        end else begin
            k_r  = K_MID_R;
            k_bl = K_MID_BL;
            k_b  = K_MID_B;
            k_br = K_MID_BR;
        end

        // left neighbor gets its bottom-left share, then goes to memory
        wb_data = sat31({1'b0, left_reg} + {1'b0, share(err, k_bl)});

        if (s1_pos_reg.last_col) begin
            right_carry_next = '0;
        end else if (s1_pos_reg.last_row) begin
            right_carry_next = {1'b0, err};
        end else begin
            right_carry_next = share(err, k_r);
        end

        if (s1_pos_reg.last_row) begin
            left_next = '0;
        end else begin
            left_next = sat31({1'b0, share(err, k_b)} + {1'b0, pend_reg});
        end

        pend_next = s1_pos_reg.last_col ? '0 : share(err, k_br);

        fwd_hit = s1_fire && (prev_col_reg == col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            right_carry_reg <= '0;
            pend_reg        <= '0;
            left_reg        <= '0;
            prev_col_reg    <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                right_carry_reg <= right_carry_next;
                pend_reg        <= pend_next;
                left_reg        <= left_next;
                prev_col_reg    <= s1_col_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg      <= s_tdata;
            s1_col_reg      <= col_reg;
            s1_pos_reg      <= pos_now;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= wb_data;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] m_data_reg;
    logic             m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_data_reg <= {sat_val[7:4], 4'b0000};
            m_last_reg <= s1_pos_reg.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `EDD_ASSERT_IMP(a_no_request_in_sweep, aclk, aresetn, clr_active_reg, !s_tready)
    `EDD_ASSERT_IMP(a_level_aligned, aclk, aresetn, m_tvalid, m_tdata[3:0] == 4'b0000)
    `EDD_ASSERT_NXT(a_fwd_captured, aclk, aresetn, accept && fwd_hit, s1_fwd_reg)
    `EDD_ASSERT_NXT(a_row_wrap, aclk, aresetn, accept && pos_now.last_col, col_reg == '0)

endmodule

`default_nettype wire

### verif/error_diffusion_dither_16_level_core_tb.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither_16_level_core_tb
// drives gray pixel requests through the 16-level dither core and checks
// every dithered pixel and its frame-end flag against a cycle-free model
// of the error diffusion, across several frame sizes and handshake stalls
// ----------------------------------------------------------------------------
`default_nettype none

module error_diffusion_dither_16_level_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import edd16_pkg::*;

    localparam int MAX_COLS = 4096;
    localparam int RANDOM_PER_PHASE = 134;

    // kinds of rows in the directed table
    typedef enum logic [0:0] {
        ROW_PIXEL  = 1'b0,
        ROW_CONFIG = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        cfg_reg_t    reg_sel;
        logic [12:0] value;      // pixel in [7:0] for pixel rows
        logic        typed;      // expected result given below
        logic [7:0]  exp_pixel;
        logic        exp_end;
    } stim_row_t;

    // one dithered output pixel as it should leave the core
    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_end;
    } dot_t;

    // dut ports
    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;    // [7:0] pixel_in
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;    // [7:0] pixel_out
    logic                 m_tlast;    // frame_end
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // model of the diffusion state, mirrors what the core should hold
    logic [4:0]           below_err [MAX_COLS];
    logic [4:0]           carry_right;
    logic [4:0]           pend_below_right;
    int unsigned          col_pos;
    int unsigned          row_pos;
    logic [12:0]          cur_width;
    logic [12:0]          cur_height;

    // dithered pixels still owed by the core, oldest first
    dot_t                 expected_dots[$];
    int                   mismatch_count = 0;

    // stall rates in percent, changed per phase
    int unsigned          src_idle_pct;
    int unsigned          snk_idle_pct;

    stim_row_t            directed_rows [22];

    always #4 aclk = ~aclk;

    error_diffusion_dither_16_level_core #(
        .MAX_WIDTH (MAX_COLS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // diffusion model
    // ------------------------------------------------------------------

    // floor(e * k / 16)
    function automatic int unsigned portion(input int unsigned e, input int unsigned k);
        return (e * k) >> 4;
    endfunction

    // error buffer entries hold at most 31
    function automatic logic [4:0] clip31(input int unsigned v);
        return (v > 31) ? 5'd31 : v[4:0];
    endfunction

    // dithers one pixel and moves the error on to its neighbors
    function automatic void dither_pixel(input logic [7:0] px, output dot_t res);
        int unsigned w, h, c, v, e;
        int unsigned kr, kbl, kb, kbr;
        logic lc, lr;
        w = cur_width;
        h = cur_height;
        if (w < 2) w = 2;
        if (w > MAX_COLS) w = MAX_COLS;
        if (h < 2) h = 2;
        c = col_pos;
        if (c >= MAX_COLS) c = MAX_COLS - 1;
        // a counter at or past the last index means last column / last row
        lc = (c + 1 >= w);
        lr = (row_pos + 1 >= h);

        v = px + carry_right + below_err[c];
        if (v > 255) v = 255;
        e = v & 15;
        res.pixel = 8'(v - e);
        res.frame_end = lc && lr;

        if (lr) begin
            // last row: nothing goes down, the right neighbor takes it all
            below_err[c] = 5'd0;
            carry_right = lc ? 5'd0 : 5'(e);
            pend_below_right = 5'd0;
        end else begin
            if (lc) begin
                kr = 0; kbl = 7; kb = 9; kbr = 0;
            end else if (c == 0) begin
                // left column: bottom-left share folded into the others
                kr = 8; kbl = 0; kb = 6; kbr = 2;
            end else begin
                kr = 7; kbl = 3; kb = 5; kbr = 1;
            end
            carry_right = 5'(portion(e, kr));
            below_err[c] = clip31(portion(e, kb) + pend_below_right);
            if (c > 0 && kbl != 0)
                below_err[c-1] = clip31(below_err[c-1] + portion(e, kbl));
            pend_below_right = 5'(portion(e, kbr));
        end

        if (lc) begin
            col_pos = 0;
            carry_right = 5'd0;
            pend_below_right = 5'd0;
            row_pos = lr ? 0 : row_pos + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // offers one pixel request, with random idle cycles ahead of it;
    // starts and ends at a falling edge
    task automatic send_pixel(input logic [7:0] px, input logic typed,
                              input logic [7:0] t_pixel, input logic t_end);
        dot_t res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        dither_pixel(px, res);
        // typed rows keep the model state but use the hand-written result
        if (typed) begin
            res.pixel = t_pixel;
            res.frame_end = t_end;
        end
        expected_dots.push_back(res);
        @(negedge aclk);
    endtask

    // lets every owed result come out so the core is idle for a register write
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_dots.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // one register write; valid is lowered in a step of its own
    task automatic write_reg(input cfg_reg_t idx, input logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_IMAGE_WIDTH)
            cur_width = val;
        else
            cur_height = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // frame dimension: mostly small, sometimes degenerate or very wide
    function automatic logic [12:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 13'($urandom_range(0, 1));
        if (r == 1) return 13'($urandom_range(4097, 8191));
        if (r == 2) return 13'($urandom_range(2000, 4096));
        return 13'($urandom_range(2, 9));
    endfunction

    // gray value with extra weight on black, white, low and high codes
    function automatic logic [7:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        if (r == 2) return 8'($urandom_range(0, 15));
        if (r == 3) return 8'($urandom_range(240, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    // receiver stalls at random, changed at the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        dot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_dots.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected pixel %0d last %0b", $realtime, m_tdata, m_tlast);
            end else begin
                want = expected_dots.pop_front();
                if (m_tdata !== want.pixel || m_tlast !== want.frame_end) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: pixel exp %0d got %0d, last exp %0b got %0b",
                                 $realtime, want.pixel, m_tdata, want.frame_end, m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned r;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        src_idle_pct = 34;
        snk_idle_pct = 76;

        // model state after reset
        for (int i = 0; i < MAX_COLS; i++) below_err[i] = 5'd0;
        carry_right = 5'd0;
        pend_below_right = 5'd0;
        col_pos = 0;
        row_pos = 0;
        cur_width = 13'd512;
        cur_height = 13'd512;

        // directed table: kind, register, value, typed, pixel, frame end
        directed_rows = '{
            // sizes below 2 act as 2: a 2x2 frame
            '{ROW_CONFIG, CFG_IMAGE_WIDTH,  13'd0,    1'b0, 8'd0,   1'b0},
            '{ROW_CONFIG, CFG_IMAGE_HEIGHT, 13'd1,    1'b0, 8'd0,   1'b0},
            // clean state, saturating white
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd255,  1'b1, 8'd240, 1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd128,  1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd255,  1'b0, 8'd0,   1'b0},
            // frame end leaves the state clear, so black stays black
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd0,    1'b1, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd15,   1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd16,   1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd241,  1'b0, 8'd0,   1'b0},
            // all ones: width clamps to the buffer depth, tall frame
            '{ROW_CONFIG, CFG_IMAGE_WIDTH,  13'h1FFF, 1'b0, 8'd0,   1'b0},
            '{ROW_CONFIG, CFG_IMAGE_HEIGHT, 13'h1FFF, 1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd255,  1'b1, 8'd240, 1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd200,  1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd7,    1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd240,  1'b0, 8'd0,   1'b0},
            // shrink mid-row: column counter is already past the new end
            '{ROW_CONFIG, CFG_IMAGE_WIDTH,  13'd3,    1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd100,  1'b0, 8'd0,   1'b0},
            // shrink height mid-frame: current row becomes the last one
            '{ROW_CONFIG, CFG_IMAGE_HEIGHT, 13'd2,    1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd30,   1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd60,   1'b0, 8'd0,   1'b0},
            '{ROW_PIXEL,  CFG_IMAGE_WIDTH,  13'd255,  1'b0, 8'd0,   1'b0}
        };

        // reset is held low, then released at a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, under the first stall pattern
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                wait_idle();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
            end else begin
                send_pixel(directed_rows[i].value[7:0], directed_rows[i].typed,
                           directed_rows[i].exp_pixel, directed_rows[i].exp_end);
            end
        end

        // random part: receiver-heavy stalls, sender-heavy stalls, none
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin src_idle_pct = 34; snk_idle_pct = 76; end
                1: begin src_idle_pct = 76; snk_idle_pct = 34; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            sent = 0;
            // new sizes at every phase start, then now and then between bursts
            wait_idle();
            write_reg(CFG_IMAGE_WIDTH, pick_size());
            write_reg(CFG_IMAGE_HEIGHT, pick_size());
            while (sent < RANDOM_PER_PHASE) begin
                r = $urandom_range(0, 5);
                if (r == 1 || r == 3) begin
                    wait_idle();
                    write_reg(CFG_IMAGE_WIDTH, pick_size());
                end
                if (r == 2 || r == 3) begin
                    wait_idle();
                    write_reg(CFG_IMAGE_HEIGHT, pick_size());
                end
                burst = $urandom_range(4, 40);
                for (int k = 0; k < burst && sent < RANDOM_PER_PHASE; k++) begin
                    send_pixel(pick_pixel(), 1'b0, 8'd0, 1'b0);
                    sent++;
                end
            end
        end

        // drain: everything owed must arrive, then a short quiet window
        s_tvalid <= 1'b0;
        while (expected_dots.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0 && expected_dots.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog: the row memory sweep plus a few hundred stalled requests
    // fit far inside this
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+hdl
hdl/edd16_pkg.sv
hdl/error_diffusion_dither_16_level_core.sv
verif/error_diffusion_dither_16_level_core_tb.sv
